>>> rtl/core/psfc_pkg.sv
// Shared types, constants and helpers of the pressure step fan controller.
`default_nettype none

package psfc_pkg;

  localparam int unsigned FREQ_W    = 15;
  localparam int unsigned TARGET_W  = 7;
  localparam int unsigned TIMEOUT_W = 15;
  localparam int unsigned PERIOD_W  = 10;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned PA_W      = 9;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  // Register indexes, at byte address 4*index
  localparam logic [2:0] REG_TARGET  = 3'd0;
  localparam logic [2:0] REG_AUTO    = 3'd1;
  localparam logic [2:0] REG_MAXFREQ = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_PERIOD  = 3'd4;

  localparam logic [TARGET_W-1:0]  RST_TARGET  = 7'd5;
  localparam logic                 RST_AUTO    = 1'b1;
  localparam logic [FREQ_W-1:0]    RST_MAXFREQ = 15'd20000;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 15'd30000;
  localparam logic [PERIOD_W-1:0]  RST_PERIOD  = 10'd1000;
  localparam logic [FREQ_W-1:0]    RST_FREQ    = 15'd2000;

  localparam logic [10:0] STEP_LARGE = 11'd1000;
  localparam logic [10:0] STEP_MID   = 11'd200;
  localparam logic [10:0] STEP_SMALL = 11'd100;

  // 2^16 / 15, rounded up; exact for quotients of values up to 2048
  localparam logic [12:0] RECIP_15 = 13'd4370;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_FAIL   = 2'd2,
    KIND_MANUAL = 2'd3
  } kind_t;

  typedef struct packed {
    logic [TARGET_W-1:0]  target_pressure;
    logic                 auto_mode;
    logic [FREQ_W-1:0]    max_frequency;
    logic [TIMEOUT_W-1:0] settle_timeout;
    logic [PERIOD_W-1:0]  refresh_period;
  } cfg_t;

  // Raw counts to whole pascals, truncated toward zero: |raw| / 16 / 15
  function automatic logic signed [PA_W-1:0] pa_of_raw(input logic signed [RAW_W-1:0] raw);
    logic [RAW_W:0]  mag;
    logic [11:0]     sixteenths;
    logic [24:0]     prod;
    logic [PA_W-1:0] quo;
    mag        = raw[RAW_W-1] ? (17'd0 - {raw[RAW_W-1], raw}) : {1'b0, raw};
    sixteenths = mag[15:4];
    prod       = {13'd0, sixteenths} * {12'd0, RECIP_15};
    quo        = {1'b0, prod[23:16]};
    return raw[RAW_W-1] ? $signed(9'd0 - quo) : $signed(quo);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/psfc_cfg_regs.sv
// Configuration register file of the pressure step fan controller.
`default_nettype none

module psfc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [psfc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [psfc_pkg::DATA_W-1:0]     pwdata,
  output logic      [psfc_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready,
  output psfc_pkg::cfg_t                       cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_pressure <= psfc_pkg::RST_TARGET;
      cfg.auto_mode       <= psfc_pkg::RST_AUTO;
      cfg.max_frequency   <= psfc_pkg::RST_MAXFREQ;
      cfg.settle_timeout  <= psfc_pkg::RST_TIMEOUT;
      cfg.refresh_period  <= psfc_pkg::RST_PERIOD;
    end else if (wr_en) begin
      unique case (idx)
        psfc_pkg::REG_TARGET:  cfg.target_pressure <= pwdata[6:0];
        psfc_pkg::REG_AUTO:    cfg.auto_mode       <= pwdata[0];
        psfc_pkg::REG_MAXFREQ: cfg.max_frequency   <= pwdata[14:0];
        psfc_pkg::REG_TIMEOUT: cfg.settle_timeout  <= pwdata[14:0];
        psfc_pkg::REG_PERIOD:  cfg.refresh_period  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      psfc_pkg::REG_TARGET:  prdata = {25'd0, cfg.target_pressure};
      psfc_pkg::REG_AUTO:    prdata = {31'd0, cfg.auto_mode};
      psfc_pkg::REG_MAXFREQ: prdata = {17'd0, cfg.max_frequency};
      psfc_pkg::REG_TIMEOUT: prdata = {17'd0, cfg.settle_timeout};
      psfc_pkg::REG_PERIOD:  prdata = {22'd0, cfg.refresh_period};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/pressure_step_fan_controller_core.sv
// Top level of the pressure step fan controller: input stage, update logic, result stage.
`default_nettype none

// Step regulator for a fan drive. Every input word yields exactly one result
// word. A word passes through two registers: the input stage, where a raw
// pressure sample is already reduced to whole pascals (divide by 240 toward
// zero, done as a shift by four and a multiply by the reciprocal of 15), and
// the result stage, loaded together with the controller state by one pass of
// short logic. A new word is taken in every cycle while the result side keeps
// up; a word moves on when the result stage is empty or being taken. Ready
// on the input side falls only when both stages are full and the result is not
// being taken. Word kinds (s_tuser): tick advances the refresh divider and the
// settle watchdog; a sample stores the pressure and, in auto mode, regulates; a
// failed read regulates on the last pressure in auto mode; manual loads the
// given frequency capped at the maximum. Regulation moves the frequency by
// 1000, 200 or 100 depending on the distance to the target, keeps it between
// zero and the maximum, and reports a pending watchdog expiry. Configuration
// goes through the APB port and should be written only while no word is in
// flight.
module pressure_step_fan_controller_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] pressure_raw, [30:16] manual_frequency, [31] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] kind
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [14:0] frequency, [15] refresh, [16] settled,
                                      // [17] timeout_report, [26:18] pressure_pa, [31:27] zero
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  psfc_pkg::cfg_t cfg;

  psfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------- input stage
  logic                                 in_valid;
  psfc_pkg::kind_t                      in_kind;
  logic signed [psfc_pkg::PA_W-1:0]     in_pa;
  logic        [psfc_pkg::FREQ_W-1:0]   in_manual;
  logic                                 advance;

  // Move the result stage on when it is empty or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= psfc_pkg::kind_t'(s_tuser);
      in_pa     <= psfc_pkg::pa_of_raw(s_tdata[15:0]);
      in_manual <= s_tdata[30:16];
    end
  end

  // ---------------------------------------------------------------- state
  logic        [psfc_pkg::FREQ_W-1:0]    freq, freq_next;
  logic signed [psfc_pkg::PA_W-1:0]      last_pa, last_pa_next;
  logic                                  in_band, in_band_next;
  logic        [psfc_pkg::TIMEOUT_W-1:0] wd_count, wd_count_next;
  logic                                  pending, pending_next;
  logic        [psfc_pkg::PERIOD_W-1:0]  ref_count, ref_count_next;
  logic                                  refresh_next, report_next;

  // ---------------------------------------------------------------- regulation
  logic signed [psfc_pkg::PA_W-1:0]      pa_use;
  logic signed [9:0]                     pa_ext, tgt_ext, lo_ext, diff;
  logic        [psfc_pkg::TARGET_W-1:0]  lo;
  logic        [10:0]                    step;
  logic                                  below, above;
  logic signed [16:0]                    fsum;
  logic        [psfc_pkg::FREQ_W-1:0]    reg_freq, man_freq;
  logic        [psfc_pkg::TIMEOUT_W-1:0] wd_dec;
  logic                                  regulate;

  // A sample regulates on its own pressure, a failed read on the stored one
  assign pa_use  = (in_kind == psfc_pkg::KIND_SAMPLE) ? in_pa : last_pa;
  assign pa_ext  = {pa_use[psfc_pkg::PA_W-1], pa_use};
  assign tgt_ext = {3'b000, cfg.target_pressure};
  assign lo      = (cfg.target_pressure == '0) ? '0 : cfg.target_pressure - 7'd1;
  assign lo_ext  = {3'b000, lo};
  assign diff    = tgt_ext - pa_ext;
  assign below   = pa_ext < lo_ext;
  assign above   = pa_ext > tgt_ext;

  always_comb begin
    if (diff > 10'sd3 || diff < -10'sd3) begin
      step = psfc_pkg::STEP_LARGE;
    end else if (diff > 10'sd1 || diff < -10'sd1) begin
      step = psfc_pkg::STEP_MID;
    end else begin
      step = psfc_pkg::STEP_SMALL;
    end
  end

  always_comb begin
    if (below) begin
      fsum = $signed({2'b00, freq}) + $signed({6'd0, step});
    end else if (above) begin
      fsum = $signed({2'b00, freq}) - $signed({6'd0, step});
    end else begin
      fsum = $signed({2'b00, freq});
    end
  end

  // Hold the frequency between zero and the maximum
  always_comb begin
    if (fsum < 17'sd0) begin
      reg_freq = '0;
    end else if (fsum > $signed({2'b00, cfg.max_frequency})) begin
      reg_freq = cfg.max_frequency;
    end else begin
      reg_freq = fsum[psfc_pkg::FREQ_W-1:0];
    end
  end

  assign man_freq = (in_manual > cfg.max_frequency) ? cfg.max_frequency : in_manual;
  assign wd_dec   = (wd_count != '0) ? wd_count - 15'd1 : '0;
  assign regulate = cfg.auto_mode &&
                    (in_kind == psfc_pkg::KIND_SAMPLE || in_kind == psfc_pkg::KIND_FAIL);

  always_comb begin
    freq_next      = freq;
    last_pa_next   = last_pa;
    in_band_next   = in_band;
    wd_count_next  = wd_count;
    pending_next   = pending;
    ref_count_next = ref_count;
    refresh_next   = 1'b0;
    report_next    = 1'b0;
    case (in_kind)
      psfc_pkg::KIND_TICK: begin
        if (ref_count >= cfg.refresh_period) begin
          refresh_next   = 1'b1;
          ref_count_next = 10'd1;
        end else begin
          ref_count_next = ref_count + 10'd1;
        end
        wd_count_next = wd_dec;
        if (wd_dec == '0 && !in_band) begin
          pending_next = 1'b1;
        end
      end
      psfc_pkg::KIND_SAMPLE,
      psfc_pkg::KIND_FAIL: begin
        if (in_kind == psfc_pkg::KIND_SAMPLE) begin
          last_pa_next = in_pa;
        end
        if (regulate) begin
          freq_next    = reg_freq;
          in_band_next = !below && !above;
          // Report a watchdog expiry once and reload the watchdog
          if (pending) begin
            report_next   = 1'b1;
            pending_next  = 1'b0;
            wd_count_next = cfg.settle_timeout;
          end
        end
      end
      psfc_pkg::KIND_MANUAL: begin
        freq_next = man_freq;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result stage
  logic update;
  assign update = advance && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      freq      <= psfc_pkg::RST_FREQ;
      last_pa   <= '0;
      in_band   <= 1'b1;
      wd_count  <= psfc_pkg::RST_TIMEOUT;
      pending   <= 1'b0;
      ref_count <= '0;
    end else begin
      if (advance) begin
        m_tvalid <= in_valid;
      end
      if (update) begin
        freq      <= freq_next;
        last_pa   <= last_pa_next;
        in_band   <= in_band_next;
        wd_count  <= wd_count_next;
        pending   <= pending_next;
        ref_count <= ref_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      m_tdata <= {5'd0, last_pa_next, report_next, in_band_next, refresh_next, freq_next};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/psfc_checker.sv
// Port-level checks of the pressure step fan controller, bound to the top level.
`default_nettype none

module psfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Drop every result after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Refresh comes only from a tick, a report only from a regulation
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[15] && m_tdata[17]))
    else $error("refresh and timeout report on one word");

  // Pressure in pascals stays within the sensor's reach
  a_pa: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[26:18]) >= -9'sd136 && $signed(m_tdata[26:18]) <= 9'sd136))
    else $error("pressure in pascals out of range");

endmodule

bind pressure_step_fan_controller_core psfc_checker u_psfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the pressure step fan controller core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psfc_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 9;
  localparam int WORDS_PER_PHASE = 105;
  localparam int COUNTS_PER_PA   = 240;
  localparam int SETTLE_CYCLES   = 4;
  // first register index that the block does not decode
  localparam logic [2:0] REG_COUNT = 3'd5;

  // One result word, unpacked
  typedef struct packed {
    logic [FREQ_W-1:0]      frequency;
    logic                   refresh;
    logic                   settled;
    logic                   timeout_report;
    logic signed [PA_W-1:0] pressure_pa;
  } fan_result_t;

  // One stimulus word; hand_checked rows carry a result typed in by hand
  typedef struct packed {
    kind_t             kind;
    logic [RAW_W-1:0]  raw;
    logic [FREQ_W-1:0] manual;
    logic              hand_checked;
    fan_result_t       want;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;   // [15:0] pressure_raw, [30:16] manual_frequency, [31] zero
  logic [1:0]  s_tuser  = '0;   // [1:0] kind
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [31:0] m_tdata;        // [14:0] frequency, [15] refresh, [16] settled,
                               // [17] timeout_report, [26:18] pressure_pa
  wire  [31:0] prdata;
  wire         pready;

  int send_idle  = 35;   // percent of cycles the sender holds back
  int recv_idle  = 61;   // percent of cycles the receiver stalls
  int fail_count = 0;
  int cycle_count = 0;

  // Controller model: configuration and state, starting from the reset values
  cfg_t                    fan_cfg = '{RST_TARGET, RST_AUTO, RST_MAXFREQ, RST_TIMEOUT, RST_PERIOD};
  logic [FREQ_W-1:0]       drive_freq      = RST_FREQ;
  logic signed [RAW_W-1:0] last_raw        = '0;
  logic                    in_band         = 1'b1;
  logic [TIMEOUT_W-1:0]    watchdog        = RST_TIMEOUT;
  logic                    timeout_pending = 1'b0;
  logic [PERIOD_W-1:0]     refresh_cnt     = '0;

  stim_row_t   words_in_flight[$];    // words offered, not yet taken by the block
  fan_result_t drive_results_due[$];  // results owed by the block, oldest first

  // Directed part: reset state, field extremes, every step size, both clamps,
  // deadband edges, negative truncation, failed reads and manual loads
  stim_row_t directed_rows [24] = '{
    // tick right after reset: nothing moves but the counters
    '{KIND_TICK,   16'd0,     15'd0,     1'b1, '{15'd2000, 1'b0, 1'b1, 1'b0, 9'sd0}},
    // zero pressure is far below the target: large step up
    '{KIND_SAMPLE, 16'd0,     15'd0,     1'b1, '{15'd3000, 1'b0, 1'b0, 1'b0, 9'sd0}},
    // positive full scale: large step down
    '{KIND_SAMPLE, 16'h7FFF,  15'd0,     1'b1, '{15'd2000, 1'b0, 1'b0, 1'b0, 9'sd136}},
    // negative full scale: large step up
    '{KIND_SAMPLE, 16'h8000,  15'd0,     1'b1, '{15'd3000, 1'b0, 1'b0, 1'b0, -9'sd136}},
    '{KIND_SAMPLE, 16'hFF11,  15'd0,     1'b0, '0},   // just under zero truncates to zero
    '{KIND_SAMPLE, 16'd1200,  15'd0,     1'b0, '0},   // on the target
    '{KIND_SAMPLE, 16'd960,   15'd0,     1'b0, '0},   // lower edge of the deadband
    '{KIND_SAMPLE, 16'd959,   15'd0,     1'b0, '0},   // two below: middle step up
    '{KIND_SAMPLE, 16'd1440,  15'd0,     1'b0, '0},   // one above: small step down
    '{KIND_SAMPLE, 16'd1680,  15'd0,     1'b0, '0},   // two above: middle step down
    '{KIND_SAMPLE, 16'd2160,  15'd0,     1'b0, '0},   // four above: large step down
    '{KIND_FAIL,   16'h1234,  15'd0,     1'b0, '0},   // failed read reuses the last pressure
    '{KIND_MANUAL, 16'hFFFF,  15'd20000, 1'b0, '0},
    '{KIND_MANUAL, 16'd0,     15'd0,     1'b0, '0},
    '{KIND_SAMPLE, 16'h7FFF,  15'd0,     1'b0, '0},   // step down from zero holds at zero
    '{KIND_MANUAL, 16'd0,     15'd19500, 1'b0, '0},
    '{KIND_SAMPLE, 16'd0,     15'd0,     1'b0, '0},   // step up caps at the maximum
    '{KIND_SAMPLE, 16'd0,     15'd0,     1'b0, '0},
    '{KIND_MANUAL, 16'h0000,  15'd16383, 1'b0, '0},
    '{KIND_SAMPLE, 16'h5555,  15'd0,     1'b0, '0},
    '{KIND_SAMPLE, 16'hAAAA,  15'd0,     1'b0, '0},
    '{KIND_TICK,   16'hFFFF,  15'd20000, 1'b0, '0},
    '{KIND_SAMPLE, 16'hFB50,  15'd0,     1'b0, '0},   // negative whole pascals
    '{KIND_FAIL,   16'hFF0F,  15'd0,     1'b0, '0}
  };

  pressure_step_fan_controller_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stall the result side at random, at the rate of the current idling mode
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Whole pascals, truncated toward zero
  function automatic int pascals(input logic signed [RAW_W-1:0] raw);
    return int'(raw) / COUNTS_PER_PA;
  endfunction

  // Hold the frequency between zero and the configured maximum
  function automatic logic [FREQ_W-1:0] cap_frequency(input int f);
    if (f < 0) return '0;
    if (f > int'(fan_cfg.max_frequency)) return fan_cfg.max_frequency;
    return FREQ_W'(f);
  endfunction

  // One regulation pass on the stored pressure; returns the watchdog report
  function automatic logic regulate_drive();
    int   pa_now;
    int   tgt;
    int   lo;
    int   gap;
    int   stride;
    int   f;
    logic report;
    pa_now = pascals(last_raw);
    tgt    = int'(fan_cfg.target_pressure);
    lo     = (tgt > 0) ? tgt - 1 : 0;
    gap    = tgt - pa_now;
    if (gap > 3 || gap < -3)      stride = int'(STEP_LARGE);
    else if (gap > 1 || gap < -1) stride = int'(STEP_MID);
    else                          stride = int'(STEP_SMALL);
    f = int'(drive_freq);
    if (pa_now < lo) begin
      f       = f + stride;
      in_band = 1'b0;
    end else if (pa_now > tgt) begin
      f       = f - stride;
      in_band = 1'b0;
    end else begin
      in_band = 1'b1;
    end
    // the cap applies inside the band too, after a lowered maximum
    drive_freq = cap_frequency(f);
    report     = timeout_pending;
    if (timeout_pending) begin
      timeout_pending = 1'b0;
      watchdog        = fan_cfg.settle_timeout;
    end
    return report;
  endfunction

  // Advance the controller by one input word and return its result word
  function automatic fan_result_t step_fan_controller(input kind_t kind,
                                                      input logic signed [RAW_W-1:0] raw,
                                                      input logic [FREQ_W-1:0] manual);
    fan_result_t r;
    r = '0;
    case (kind)
      KIND_TICK: begin
        if (refresh_cnt >= fan_cfg.refresh_period) begin
          r.refresh   = 1'b1;
          refresh_cnt = '0;
        end
        refresh_cnt = refresh_cnt + 1'b1;
        if (watchdog != '0) watchdog = watchdog - 1'b1;
        if (watchdog == '0 && !in_band) timeout_pending = 1'b1;
      end
      KIND_SAMPLE: begin
        last_raw = raw;
        if (fan_cfg.auto_mode) r.timeout_report = regulate_drive();
      end
      KIND_FAIL: begin
        if (fan_cfg.auto_mode) r.timeout_report = regulate_drive();
      end
      default: begin
        drive_freq = cap_frequency(int'(manual));
      end
    endcase
    r.frequency   = drive_freq;
    r.settled     = in_band;
    r.pressure_pa = PA_W'(pascals(last_raw));
    return r;
  endfunction

  // Check each result word against the oldest one owed, then log any word
  // taken in at this edge; results come out first so the order is fixed
  always @(posedge clk) begin : watch_words
    fan_result_t seen;
    fan_result_t due;
    stim_row_t   row;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen.frequency      = m_tdata[14:0];
        seen.refresh        = m_tdata[15];
        seen.settled        = m_tdata[16];
        seen.timeout_report = m_tdata[17];
        seen.pressure_pa    = m_tdata[26:18];
        if (drive_results_due.size() == 0) begin
          $error("result word with no result owed");
          fail_count++;
        end else begin
          due = drive_results_due.pop_front();
          if (seen.frequency !== due.frequency) begin
            $error("frequency: expected %0d, got %0d", due.frequency, seen.frequency);
            fail_count++;
          end
          if (seen.refresh !== due.refresh) begin
            $error("refresh: expected %0d, got %0d", due.refresh, seen.refresh);
            fail_count++;
          end
          if (seen.settled !== due.settled) begin
            $error("settled: expected %0d, got %0d", due.settled, seen.settled);
            fail_count++;
          end
          if (seen.timeout_report !== due.timeout_report) begin
            $error("timeout_report: expected %0d, got %0d", due.timeout_report,
                   seen.timeout_report);
            fail_count++;
          end
          if (seen.pressure_pa !== due.pressure_pa) begin
            $error("pressure_pa: expected %0d, got %0d", due.pressure_pa, seen.pressure_pa);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        row = words_in_flight.pop_front();
        // always step the model so its state stays in line with the block
        due = step_fan_controller(kind_t'(s_tuser), s_tdata[15:0], s_tdata[30:16]);
        drive_results_due.push_back(row.hand_checked ? row.want : due);
      end
    end
  end

  // Offer one word after a random gap and hold it until the block takes it
  task automatic send_word(input stim_row_t row);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    words_in_flight.push_back(row);
    s_tvalid <= 1'b1;
    s_tuser  <= row.kind;
    s_tdata  <= {1'b0, row.manual, row.raw};
    do @(posedge clk); while (!s_tready);
  endtask

  // Wait until every owed result is in, then let the pipeline settle
  task automatic drain();
    while (drive_results_due.size() != 0 || words_in_flight.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register over APB: setup, then access until pready
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TARGET:  fan_cfg.target_pressure = value[TARGET_W-1:0];
      REG_AUTO:    fan_cfg.auto_mode       = value[0];
      REG_MAXFREQ: fan_cfg.max_frequency   = value[FREQ_W-1:0];
      REG_TIMEOUT: fan_cfg.settle_timeout  = value[TIMEOUT_W-1:0];
      REG_PERIOD:  fan_cfg.refresh_period  = value[PERIOD_W-1:0];
      default: ;   // undecoded index: the block drops the write
    endcase
  endtask

  // Set stray bits above the field now and then; the block must drop them
  function automatic logic [31:0] add_stray_bits(input logic [31:0] v, input int width);
    if ($urandom_range(0, 1) == 1) return v | ($urandom << width);
    return v;
  endfunction

  // Program a full set of registers for one phase; the first two take the extremes
  task automatic load_settings(input int phase);
    cfg_t next;
    case (phase)
      0: next = '{7'd0,   1'b1, 15'd20000, 15'd1,     10'd1};
      1: next = '{7'd127, 1'b1, 15'd0,     15'd32767, 10'd1023};
      default: begin
        next.target_pressure = TARGET_W'($urandom_range(0, 127));
        // phase two runs in manual mode; later phases mostly regulate
        next.auto_mode       = (phase != 2) && ($urandom_range(0, 4) != 0);
        next.max_frequency   = FREQ_W'($urandom_range(0, 20000));
        next.settle_timeout  = TIMEOUT_W'($urandom_range(1, 60));
        next.refresh_period  = PERIOD_W'($urandom_range(1, 30));
      end
    endcase
    reg_write(REG_TARGET,  add_stray_bits(32'(next.target_pressure), TARGET_W));
    reg_write(REG_AUTO,    add_stray_bits(32'(next.auto_mode), 1));
    reg_write(REG_MAXFREQ, add_stray_bits(32'(next.max_frequency), FREQ_W));
    reg_write(REG_TIMEOUT, add_stray_bits(32'(next.settle_timeout), TIMEOUT_W));
    reg_write(REG_PERIOD,  add_stray_bits(32'(next.refresh_period), PERIOD_W));
    reg_write(3'($urandom_range(int'(REG_COUNT), 7)), $urandom);
  endtask

  // Random word: mostly pressures close to the target so the deadband,
  // every step size and the watchdog all come into play
  function automatic stim_row_t random_word();
    stim_row_t row;
    int        pick;
    int        level;
    row        = '0;
    pick       = $urandom_range(0, 99);
    row.manual = FREQ_W'($urandom_range(0, 20000));
    row.raw    = RAW_W'($urandom);
    if (pick < 40)      row.kind = KIND_TICK;
    else if (pick < 75) row.kind = KIND_SAMPLE;
    else if (pick < 87) row.kind = KIND_FAIL;
    else                row.kind = KIND_MANUAL;
    if (row.kind == KIND_SAMPLE && $urandom_range(0, 9) < 7) begin
      level = (int'(fan_cfg.target_pressure) + int'($urandom_range(0, 12)) - 6) * COUNTS_PER_PA
              + int'($urandom_range(0, 478)) - 239;
      if (level > 32767)  level = 32767;
      if (level < -32768) level = -32768;
      row.raw = RAW_W'(level);
    end
    return row;
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed words run on the reset settings
    foreach (directed_rows[i]) send_word(directed_rows[i]);
    s_tvalid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      // swap the idling rates a third of the way in, drop them for the last third
      if (phase == PHASES / 3) begin
        send_idle = 61;
        recv_idle = 35;
      end else if (phase == 2 * PHASES / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      load_settings(phase);
      repeat (WORDS_PER_PHASE) send_word(random_word());
      s_tvalid <= 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
